// ===== src/rayaabb_pkg.sv =====
// ----------------------------------------------------------------------------
// rayaabb_pkg
// Shared constants and controller/datapath interface types for the ray versus
// box slab test core.
// ----------------------------------------------------------------------------
package rayaabb_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned TW       = 31;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned AxisW    = 2;
  localparam int unsigned InDataW  = 224;
  localparam int unsigned OutDataW = 32;

  // 1e-4 in Q16.16, rounded to nearest
  localparam logic [CoordW-1:0] EpsQ = 32'd7;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTest = 1'b1;

  typedef struct packed {
    logic             capture;    // latch the accepted beat, init clip interval
    logic [AxisW-1:0] axis;
    logic             div_start;
    logic             st_ray;     // write ray state for axis
    logic             diff_en;    // corner minus origin, parallel slab check
    logic             mul_en;
    logic             mul_hi;     // multiply the max-corner difference
    logic             sat_lo_en;
    logic             sat_hi_en;
    logic             clip_en;
    logic             emit;       // load the output register
  } cmd_t;

  typedef struct packed {
    logic small_dir;  // direction magnitude at most epsilon
    logic div_done;
    logic axis_par;
  } status_t;

endpackage

// ===== src/ray_aabb_slab_test_core.sv =====
// ----------------------------------------------------------------------------
// ray_aabb_slab_test_core
// Ray versus axis-aligned box test by the slab method in Q16.16 fixed point.
// Box test: per non-parallel axis subtract, two multiplies, saturate and clip;
// a parallel axis only gets the subtract and slab check; then emit the result.
// Ray load: a parallel axis is stored directly, a non-parallel one waits for the
// bit-serial reciprocal divider. One item in flight: the next beat is taken
// only once the load or box test is done; a box test can wait on output stalls.
// Reset clears the ray to origin zero with every axis parallel.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z, limit_t, pad
  input  logic [rayaabb_pkg::InDataW-1:0]   s_axis_tdata_i,
  // cmd
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // box_hit, near_t
  output logic [rayaabb_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import rayaabb_pkg::*;

  cmd_t          cmd;
  status_t       status;
  logic          out_hit;
  logic [TW-1:0] out_near;

  rayaabb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rayaabb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_hit_o  (out_hit),
    .out_near_o (out_near)
  );

  assign m_axis_tdata_o = {out_near, out_hit};

endmodule

// ===== src/rayaabb_div.sv =====
// ----------------------------------------------------------------------------
// rayaabb_div
// Restoring divider: computes 2^32 / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rayaabb_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rayaabb_pkg::CoordW-1:0]      den_i,
  output logic [rayaabb_pkg::CoordW-1:0]      quo_o,
  output logic                                done_o
);
  import rayaabb_pkg::*;

  localparam int unsigned Steps = CoordW + 1;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CoordW-1:0]   den_q;
  logic [CoordW-1:0]   rem_q, rem_d;
  logic [CoordW:0]     quo_q, quo_d;
  logic [CoordW:0]     trial;
  logic                qbit;

  // dividend is a single one in its top bit
  assign trial = {rem_q, (cnt_q == '0)};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? CoordW'(trial - {1'b0, den_q}) : trial[CoordW-1:0];
      quo_d = {quo_q[CoordW-1:0], qbit};
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  // quotient never exceeds 2^29 since den is above epsilon
  assign quo_o  = quo_q[CoordW-1:0];
  assign done_o = done_q;

endmodule

// ===== src/rayaabb_dp.sv =====
// ----------------------------------------------------------------------------
// rayaabb_dp
// Datapath: ray state, reciprocal divider, slab multiplier, clipping interval.
// ----------------------------------------------------------------------------
module rayaabb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [rayaabb_pkg::InDataW-1:0]     in_data_i,
  input  rayaabb_pkg::cmd_t                   cmd_i,
  output rayaabb_pkg::status_t                status_o,
  output logic                                out_hit_o,
  output logic [rayaabb_pkg::TW-1:0]          out_near_o
);
  import rayaabb_pkg::*;

  // floor shift by 16, then clamp to signed 32 bits
  function automatic logic signed [CoordW-1:0] sat_shift16(input logic signed [64:0] p);
    logic signed [48:0] q;
    q = p[64:16];
    if (q[48:31] != {18{q[48]}}) begin
      sat_shift16 = q[48] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      sat_shift16 = q[CoordW-1:0];
    end
  endfunction

  logic signed [CoordW-1:0] first_q  [NumAxes];
  logic signed [CoordW-1:0] second_q [NumAxes];

  logic signed [CoordW-1:0] org_q [NumAxes];
  logic signed [CoordW-1:0] inv_q [NumAxes];
  logic [NumAxes-1:0]       par_q;

  logic signed [CoordW:0]   dlo_q, dhi_q;
  logic signed [64:0]       prod_q;
  logic signed [CoordW-1:0] tlo_q, thi_q, tmin_q, tmax_q;
  logic                     miss_q;
  logic                     hit_q;
  logic [TW-1:0]            near_q;

  logic [AxisW-1:0]         ax;
  logic signed [CoordW-1:0] d_sel, lo_sel, hi_sel, org_sel;
  logic [CoordW-1:0]        mag, quo;
  logic                     small_dir, div_done;
  logic signed [CoordW-1:0] quo_signed;
  logic signed [CoordW-1:0] t0, t1;
  logic                     hit;

  assign ax      = cmd_i.axis;
  assign d_sel   = second_q[ax];
  assign lo_sel  = first_q[ax];
  assign hi_sel  = second_q[ax];
  assign org_sel = org_q[ax];

  assign mag       = d_sel[CoordW-1] ? (~d_sel + 1'b1) : d_sel;
  assign small_dir = (mag <= EpsQ);

  rayaabb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (mag),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign quo_signed = d_sel[CoordW-1] ? -$signed(quo) : $signed(quo);

  assign t0 = (tlo_q > thi_q) ? thi_q : tlo_q;
  assign t1 = (tlo_q > thi_q) ? tlo_q : thi_q;

  assign hit = !miss_q && !(tmin_q > tmax_q) && (tmax_q > $signed(EpsQ));

  assign status_o.small_dir = small_dir;
  assign status_o.div_done  = div_done;
  assign status_o.axis_par  = par_q[ax];

  // ray state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        org_q[a] <= '0;
        inv_q[a] <= '0;
      end
      par_q <= '1;
    end else if (cmd_i.st_ray) begin
      org_q[ax] <= lo_sel;
      par_q[ax] <= small_dir;
      inv_q[ax] <= small_dir ? '0 : quo_signed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int a = 0; a < NumAxes; a++) begin
        first_q[a]  <= in_data_i[a*CoordW +: CoordW];
        second_q[a] <= in_data_i[(a+NumAxes)*CoordW +: CoordW];
      end
    end

    if (cmd_i.diff_en) begin
      dlo_q <= {lo_sel[CoordW-1], lo_sel} - {org_sel[CoordW-1], org_sel};
      dhi_q <= {hi_sel[CoordW-1], hi_sel} - {org_sel[CoordW-1], org_sel};
    end

    if (cmd_i.mul_en) begin
      prod_q <= (cmd_i.mul_hi ? dhi_q : dlo_q) * inv_q[ax];
    end
    if (cmd_i.sat_lo_en) tlo_q <= sat_shift16(prod_q);
    if (cmd_i.sat_hi_en) thi_q <= sat_shift16(prod_q);

    if (cmd_i.capture) begin
      tmin_q <= $signed(EpsQ);
      tmax_q <= $signed({1'b0, in_data_i[2*NumAxes*CoordW +: TW]});
      miss_q <= 1'b0;
    end else begin
      if (cmd_i.diff_en && par_q[ax] && (org_sel < lo_sel || org_sel > hi_sel)) begin
        miss_q <= 1'b1;
      end
      if (cmd_i.clip_en) begin
        if (t0 > tmin_q) tmin_q <= t0;
        if (t1 < tmax_q) tmax_q <= t1;
      end
    end

    if (cmd_i.emit) begin
      hit_q  <= hit;
      near_q <= hit ? tmin_q[TW-1:0] : '0;
    end
  end

  assign out_hit_o  = hit_q;
  assign out_near_o = near_q;

endmodule

// ===== src/rayaabb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rayaabb_ctrl
// Sequencer: walks the three axes for ray loads and box tests, and owns the
// input handshake and the output valid flag.
// ----------------------------------------------------------------------------
module rayaabb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_cmd_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rayaabb_pkg::cmd_t      cmd_o,
  input  rayaabb_pkg::status_t   status_i
);
  import rayaabb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LD_CHK  = 9'b000000010,
    S_LD_DIV  = 9'b000000100,
    S_TS_DIFF = 9'b000001000,
    S_TS_MLO  = 9'b000010000,
    S_TS_MHI  = 9'b000100000,
    S_TS_SAT  = 9'b001000000,
    S_TS_CLIP = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  localparam logic [AxisW-1:0] LastAxis = AxisW'(NumAxes - 1);

  state_e           state_q, state_d;
  logic [AxisW-1:0] axis_q, axis_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             last_axis;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_axis  = (axis_q == LastAxis);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          axis_d  = '0;
          state_d = (in_cmd_i == CmdLoad) ? S_LD_CHK : S_TS_DIFF;
        end
      end
      S_LD_CHK: begin
        if (status_i.small_dir) begin
          cmd_o.st_ray = 1'b1;
          axis_d  = last_axis ? '0 : axis_q + 1'b1;
          state_d = last_axis ? S_IDLE : S_LD_CHK;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_LD_DIV;
        end
      end
      S_LD_DIV: begin
        if (status_i.div_done) begin
          cmd_o.st_ray = 1'b1;
          axis_d  = last_axis ? '0 : axis_q + 1'b1;
          state_d = last_axis ? S_IDLE : S_LD_CHK;
        end
      end
      S_TS_DIFF: begin
        cmd_o.diff_en = 1'b1;
        if (status_i.axis_par) begin
          axis_d  = last_axis ? '0 : axis_q + 1'b1;
          state_d = last_axis ? S_EMIT : S_TS_DIFF;
        end else begin
          state_d = S_TS_MLO;
        end
      end
      S_TS_MLO: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_TS_MHI;
      end
      S_TS_MHI: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_hi    = 1'b1;
        cmd_o.sat_lo_en = 1'b1;
        state_d = S_TS_SAT;
      end
      S_TS_SAT: begin
        cmd_o.sat_hi_en = 1'b1;
        state_d = S_TS_CLIP;
      end
      S_TS_CLIP: begin
        cmd_o.clip_en = 1'b1;
        axis_d  = last_axis ? '0 : axis_q + 1'b1;
        state_d = last_axis ? S_EMIT : S_TS_DIFF;
      end
      S_EMIT: begin
        // wait until the previous result beat has left
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second beat accepted while an item is in flight");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending output beat");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_LD_DIV))
    else $error("divider finished outside a ray load");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (axis_q <= LastAxis))
    else $error("axis counter past last axis");

endmodule
